### rtl/pxcell_pkg.sv
// ----------------------------------------------------------------------------
// Pixel to cell package
// Shared widths, payload structs, register codes and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pxcell_pkg;

  localparam int PIX_W          = 16;
  localparam int OFS_W          = 21;
  localparam int FS_W           = 10;
  localparam int POS_W          = 22;
  localparam int CELL_W         = 16;
  localparam int MAX_FIELD_SIZE = 1023;
  localparam int FRAC_BITS      = 16;

  localparam logic [FS_W-1:0] FS_RESET = FS_W'(16);

  // sqrt(3)/2 and sqrt(3)/3 as 32-bit fractions
  localparam longint unsigned K2_Q32 = 64'd3719550787;
  localparam longint unsigned K3_Q32 = 64'd2479700525;

  typedef enum logic [1:0] {
    REG_FIELD_SIZE = 2'd0,
    REG_HEX_MODE   = 2'd1,
    REG_OFFSET_X   = 2'd2,
    REG_OFFSET_Y   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
  } pxcell_in_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] cell_x;
    logic signed [CELL_W-1:0] cell_y;
  } pxcell_out_t;

  // round a 32-bit fraction to nearest at f fractional bits
  function automatic longint unsigned round_frac(input longint unsigned k32, input int f);
    return (k32 + (64'd1 << (31 - f))) >> (32 - f);
  endfunction

  // clip a cell coordinate to 16 bits signed
  function automatic logic signed [CELL_W-1:0] sat_cell(input logic signed [23:0] v);
    logic signed [CELL_W-1:0] res;
    if (v > 24'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -24'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[CELL_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/pxcell_div.sv
// ----------------------------------------------------------------------------
// Pixel to cell floor divider
// Restoring divider, one quotient bit per stage, floor rounding for signed
// dividends and a sideband word carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module pxcell_div #(
  parameter int DW = 38,
  parameter int VW = 26,
  parameter int QW = 22,
  parameter int SW = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [DW-1:0] dividend,
  input  wire logic [VW-1:0]        divisor,
  input  wire logic [SW-1:0]        side,
  output logic                      out_valid,
  output logic signed [QW:0]        quo,
  output logic [VW-1:0]             rem,
  output logic [SW-1:0]             side_out
);

  logic          st_valid [QW];
  logic [VW-1:0] st_rem   [QW];
  logic [QW-1:0] st_quo   [QW];
  logic [DW-1:0] st_u     [QW];
  logic          st_neg   [QW];
  logic [VW-1:0] st_b     [QW];
  logic [SW-1:0] st_side  [QW];

  logic [DW-1:0] u_in;

  // fold a negative dividend to its complement; undo at the end
  assign u_in = dividend[DW-1] ? ~dividend : dividend;

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic          valid_prev;
    logic [VW-1:0] rem_prev;
    logic [QW-1:0] quo_prev;
    logic [DW-1:0] u_prev;
    logic          neg_prev;
    logic [VW-1:0] b_prev;
    logic [SW-1:0] side_prev;
    logic [VW:0]   trial;
    logic          fits;

    if (i == 0) begin : g_first
      assign valid_prev = in_valid;
      assign rem_prev   = VW'(u_in[DW-1:QW]);
      assign quo_prev   = '0;
      assign u_prev     = u_in;
      assign neg_prev   = dividend[DW-1];
      assign b_prev     = divisor;
      assign side_prev  = side;
    end else begin : g_next
      assign valid_prev = st_valid[i-1];
      assign rem_prev   = st_rem[i-1];
      assign quo_prev   = st_quo[i-1];
      assign u_prev     = st_u[i-1];
      assign neg_prev   = st_neg[i-1];
      assign b_prev     = st_b[i-1];
      assign side_prev  = st_side[i-1];
    end

    assign trial = {rem_prev, u_prev[QW-1-i]};
    assign fits  = trial >= {1'b0, b_prev};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[i] <= 1'b0;
      end else if (en) begin
        st_valid[i] <= valid_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[i]  <= fits ? VW'(trial - {1'b0, b_prev}) : trial[VW-1:0];
        st_quo[i]  <= {quo_prev[QW-2:0], fits};
        st_u[i]    <= u_prev;
        st_neg[i]  <= neg_prev;
        st_b[i]    <= b_prev;
        st_side[i] <= side_prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st_valid[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo      <= st_neg[QW-1] ? ~{1'b0, st_quo[QW-1]} : {1'b0, st_quo[QW-1]};
      rem      <= st_neg[QW-1] ? VW'(st_b[QW-1] - st_rem[QW-1] - VW'(1)) : st_rem[QW-1];
      side_out <= st_side[QW-1];
    end
  end

endmodule

`default_nettype wire

### rtl/pixel_to_hex_or_square_cell.sv
// ----------------------------------------------------------------------------
// Pixel to hexagonal or square grid cell
// Offsets a pixel position and returns the grid cell that holds it.
// ----------------------------------------------------------------------------
// One position word enters per clock and one cell word leaves per clock, unless
// out_stall holds a result. Each word passes 27 registers: the input register,
// a 22-stage restoring divider plus its result register, two corner-test stages
// and the output register. The input register loads at the accepting edge. The
// divider length is set by the 22 quotient bits of a 22-bit offset position.
// When out_stall holds a result, the whole pipeline freezes and in_stall rises
// in the same cycle. The configuration port is always ready; write it only
// while the pipeline is empty. Square mode floor-divides each coordinate by
// field_size; hexagon mode uses columns field_size*sqrt(3)/2 wide, odd columns
// shifted down by half a cell, and an exact corner test in Q(FRAC_BITS) fixed
// point.
`default_nettype none

module pixel_to_hex_or_square_cell #(
  parameter int FRAC_BITS = pxcell_pkg::FRAC_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire pxcell_pkg::pxcell_in_t       in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output pxcell_pkg::pxcell_out_t           out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [pxcell_pkg::OFS_W-1:0] cfg_data
);

  import pxcell_pkg::*;

  localparam int XD_W = POS_W + FRAC_BITS;   // x dividend, scaled position
  localparam int XV_W = FS_W + FRAC_BITS;    // x divisor, column width
  localparam int YD_W = POS_W + 1;           // y dividend, doubled position
  localparam int YV_W = FS_W + 1;            // y divisor, doubled size
  localparam int LHS_W = XV_W + 1;

  localparam logic [FRAC_BITS-1:0] K2 = FRAC_BITS'(round_frac(K2_Q32, FRAC_BITS));
  localparam logic [FRAC_BITS-1:0] K3 = FRAC_BITS'(round_frac(K3_Q32, FRAC_BITS));

  // configuration
  logic [FS_W-1:0]         field_size;
  logic                    hex_mode;
  logic signed [OFS_W-1:0] offset_x;
  logic signed [OFS_W-1:0] offset_y;

  // pipeline advance: hold everything while a result waits
  logic en;

  // input stage
  logic                    s0_valid;
  logic signed [POS_W-1:0] s0_px;
  logic signed [POS_W-1:0] s0_py;
  logic [FS_W-1:0]         s0_fs;
  logic [XV_W-1:0]         s0_side;
  logic                    s0_hex;
  logic [FS_W-1:0]         fs_clamped;

  // divider ports
  logic signed [XD_W-1:0]  xdiv_a;
  logic [XV_W-1:0]         xdiv_b;
  logic                    xdiv_valid;
  logic signed [POS_W:0]   xdiv_q;
  logic [XV_W-1:0]         xdiv_r;
  logic [FS_W-1:0]         xdiv_fs;
  logic                    ydiv_valid;
  logic signed [POS_W:0]   ydiv_q;
  logic [YV_W-1:0]         ydiv_r;
  logic                    ydiv_hex;

  // row fix-up
  logic                    odd;
  logic [YV_W:0]           row_sum;
  logic                    row_wrap;
  logic [YV_W-1:0]         row_rem;
  logic                    dev_neg;
  logic [FS_W-1:0]         dev_mag;

  logic                    p1_valid;
  logic signed [POS_W:0]   p1_ci;
  logic [XV_W-1:0]         p1_cx;
  logic signed [23:0]      p1_cj;
  logic [FS_W-1:0]         p1_mag;
  logic                    p1_neg;
  logic                    p1_odd;
  logic                    p1_hex;

  logic                    p2_valid;
  logic [LHS_W-1:0]        p2_lhs;
  logic [XV_W-1:0]         p2_rhs;
  logic signed [POS_W:0]   p2_ci;
  logic signed [23:0]      p2_cj;
  logic                    p2_neg;
  logic                    p2_odd;
  logic                    p2_hex;

  logic                    corner;
  logic signed [23:0]      cell_x_full;
  logic signed [23:0]      cell_y_full;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // register writes; unknown codes cannot occur on a two-bit index
  always_ff @(posedge clk) begin
    if (rst) begin
      field_size <= FS_RESET;
      hex_mode   <= 1'b0;
      offset_x   <= '0;
      offset_y   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FIELD_SIZE: field_size <= cfg_data[FS_W-1:0];
        REG_HEX_MODE:   hex_mode   <= cfg_data[0];
        REG_OFFSET_X:   offset_x   <= cfg_data;
        REG_OFFSET_Y:   offset_y   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // a zero size counts as one, an oversized one clips to the maximum
  always_comb begin
    if (field_size == '0) begin
      fs_clamped = FS_W'(1);
    end else if ({7'b0, field_size} > 17'(MAX_FIELD_SIZE)) begin
      fs_clamped = FS_W'(MAX_FIELD_SIZE);
    end else begin
      fs_clamped = field_size;
    end
  end

  // stage 0: add scroll offsets, form the column width in Q(FRAC_BITS)
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_px   <= POS_W'(in_data.pixel_x) + POS_W'(offset_x);
      s0_py   <= POS_W'(in_data.pixel_y) + POS_W'(offset_y);
      s0_fs   <= fs_clamped;
      s0_side <= XV_W'(fs_clamped) * XV_W'(K2);
      s0_hex  <= hex_mode;
    end
  end

  // hexagon columns divide the scaled position by the column width
  assign xdiv_a = s0_hex ? {s0_px, {FRAC_BITS{1'b0}}} : XD_W'(s0_px);
  assign xdiv_b = s0_hex ? s0_side : XV_W'(s0_fs);

  pxcell_div #(
    .DW (XD_W),
    .VW (XV_W),
    .QW (POS_W),
    .SW (FS_W)
  ) u_xdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s0_valid),
    .dividend  (xdiv_a),
    .divisor   (xdiv_b),
    .side      (s0_fs),
    .out_valid (xdiv_valid),
    .quo       (xdiv_q),
    .rem       (xdiv_r),
    .side_out  (xdiv_fs)
  );

  // rows divide 2*py by 2*size; the odd-column half shift is added after
  pxcell_div #(
    .DW (YD_W),
    .VW (YV_W),
    .QW (POS_W),
    .SW (1)
  ) u_ydiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s0_valid),
    .dividend  ({s0_py, 1'b0}),
    .divisor   ({s0_fs, 1'b0}),
    .side      (s0_hex),
    .out_valid (ydiv_valid),
    .quo       (ydiv_q),
    .rem       (ydiv_r),
    .side_out  (ydiv_hex)
  );

  // odd columns shift down half a cell: add size to the doubled remainder
  always_comb begin
    odd      = ydiv_hex && xdiv_q[0];
    row_sum  = {1'b0, ydiv_r} + (odd ? (YV_W + 1)'(xdiv_fs) : '0);
    row_wrap = row_sum >= {1'b0, xdiv_fs, 1'b0};
    row_rem  = row_wrap ? YV_W'(row_sum - {1'b0, xdiv_fs, 1'b0}) : row_sum[YV_W-1:0];
    dev_neg  = row_rem > YV_W'(xdiv_fs);
    dev_mag  = dev_neg ? FS_W'(row_rem - YV_W'(xdiv_fs)) : FS_W'(YV_W'(xdiv_fs) - row_rem);
  end

  // stage p1: row quotient settled, distance from the cell centre line
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= xdiv_valid && ydiv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_ci  <= xdiv_q;
      p1_cx  <= xdiv_r;
      p1_cj  <= 24'(ydiv_q) + 24'(row_wrap);
      p1_mag <= dev_mag;
      p1_neg <= dev_neg;
      p1_odd <= odd;
      p1_hex <= ydiv_hex;
    end
  end

  // stage p2: corner slope product against twice the column remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_lhs <= {p1_cx, 1'b0};
      p2_rhs <= XV_W'(K3) * XV_W'(p1_mag);
      p2_ci  <= p1_ci;
      p2_cj  <= p1_cj;
      p2_neg <= p1_neg;
      p2_odd <= p1_odd;
      p2_hex <= p1_hex;
    end
  end

  // stage p3: a point in the slanted corner belongs to the previous column
  always_comb begin
    corner      = p2_hex && (p2_lhs <= LHS_W'(p2_rhs));
    cell_x_full = 24'(p2_ci) - 24'(corner);
    cell_y_full = p2_cj - 24'(corner && p2_odd) + 24'(corner && p2_neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.cell_x <= sat_cell(cell_x_full);
      out_data.cell_y <= sat_cell(cell_y_full);
    end
  end

endmodule

`default_nettype wire

### tb/pxcell_checker.sv
// ----------------------------------------------------------------------------
// Pixel to cell checker
// Watches the position, cell and register channels, predicts each cell word
// from the accepted position word and the current register values, and
// compares the two field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module pxcell_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire pxcell_pkg::pxcell_in_t       in_data,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire pxcell_pkg::pxcell_out_t      out_data,
  input  wire logic                         cfg_valid,
  input  wire logic                         cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [pxcell_pkg::OFS_W-1:0] cfg_data,
  output int                                fails,
  output int                                pending
);
  import pxcell_pkg::*;

  localparam longint ONE  = longint'(1) << FRAC_BITS;
  localparam longint HEXW = longint'((K2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam longint CORN = longint'((K3_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

  logic [FS_W-1:0]         size_reg;
  logic                    hex_reg;
  logic signed [OFS_W-1:0] shift_x;
  logic signed [OFS_W-1:0] shift_y;
  pxcell_out_t             cells_due[$];

  function automatic longint floor_quot(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [CELL_W-1:0] clip_cell(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[CELL_W-1:0];
  endfunction

  function automatic pxcell_out_t cell_of(input pxcell_in_t pos);
    pxcell_out_t r;
    longint fs, px, py, col, row;
    longint side, span, half, ci, cx, ty, cj, cy, dev, mag;
    logic odd;
    fs = longint'(size_reg);
    if (fs < 1) fs = 1;
    if (fs > MAX_FIELD_SIZE) fs = MAX_FIELD_SIZE;
    px = longint'(pos.pixel_x) + longint'(shift_x);
    py = longint'(pos.pixel_y) + longint'(shift_y);
    if (!hex_reg) begin
      col = floor_quot(px, fs);
      row = floor_quot(py, fs);
    end else begin
      side = fs * HEXW;
      span = fs * ONE;
      half = fs * (ONE >> 1);
      ci   = floor_quot(px * ONE, side);
      cx   = px * ONE - side * ci;
      odd  = ci[0];
      ty   = py * ONE + (odd ? half : 0);
      cj   = floor_quot(ty, span);
      cy   = ty - span * cj;
      dev  = half - cy;
      mag  = (dev < 0) ? -dev : dev;
      col  = ci;
      row  = cj;
      // corner test: the point belongs to the column on the left
      if ((cx << FRAC_BITS) <= CORN * mag) begin
        col = col - 1;
        if (odd) row = row - 1;
        if (dev < 0) row = row + 1;
      end
    end
    r.cell_x = clip_cell(col);
    r.cell_y = clip_cell(row);
    return r;
  endfunction

  assign pending = cells_due.size();

  always @(posedge clk) begin
    pxcell_out_t want;
    if (rst) begin
      size_reg <= FS_RESET;
      hex_reg  <= 1'b0;
      shift_x  <= '0;
      shift_y  <= '0;
      cells_due.delete();
      fails    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_FIELD_SIZE: size_reg <= cfg_data[FS_W-1:0];
          REG_HEX_MODE:   hex_reg  <= cfg_data[0];
          REG_OFFSET_X:   shift_x  <= cfg_data;
          REG_OFFSET_Y:   shift_y  <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) cells_due.push_back(cell_of(in_data));
      if (out_valid && !out_stall) begin
        if (cells_due.size() == 0) begin
          fails <= fails + 1;
          $display("%0t: unexpected cell word x=%0d y=%0d", $time,
                   out_data.cell_x, out_data.cell_y);
        end else begin
          want = cells_due.pop_front();
          if (want.cell_x !== out_data.cell_x || want.cell_y !== out_data.cell_y) begin
            fails <= fails + 1;
            $display("%0t: cell mismatch expected x=%0d y=%0d actual x=%0d y=%0d",
                     $time, want.cell_x, want.cell_y, out_data.cell_x,
                     out_data.cell_y);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Pixel to cell testbench
// Drives position words through several register settings, square and
// hexagonal, with random gaps and output stalls; a checker beside the block
// predicts every cell word and this top gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import pxcell_pkg::*;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  pxcell_in_t          in_data;
  logic                out_valid;
  logic                out_stall;
  pxcell_out_t         out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [OFS_W-1:0]    cfg_data;
  int                  fails;
  int                  pending;
  logic                quiet;      // phase with no idling on either side
  int                  stall_left;
  logic [FS_W-1:0]     cur_size;

  pixel_to_hex_or_square_cell u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  pxcell_checker u_check (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fails, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit: far beyond the slowest correct run
  initial begin
    #10000000;
    $display("pixel_to_hex_or_square_cell test failed");
    $finish;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver side: hold out_stall for random stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall  <= ($urandom_range(0, 3) == 0);
      stall_left <= gap_len();
    end
  end

  // Offer one register word and hold it until taken; the caller drops valid
  task automatic write_reg(input cfg_reg_t idx, input logic [OFS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk iff cfg_ready);
  endtask

  // Drop valid for a random gap, then offer one position word until taken
  task automatic send_pos(input logic signed [15:0] x, input logic signed [15:0] y);
    int g;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.pixel_x <= x;
    in_data.pixel_y <= y;
    @(posedge clk iff !in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_regs(input logic [FS_W-1:0] fs, input logic hex,
                          input logic [OFS_W-1:0] ox, input logic [OFS_W-1:0] oy);
    write_reg(REG_FIELD_SIZE, OFS_W'(fs));
    write_reg(REG_HEX_MODE, OFS_W'(hex));
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    cfg_valid <= 1'b0;
    cur_size = fs;
  endtask

  task automatic directed_set();
    send_pos(-16'sd32768, -16'sd32768);
    send_pos(16'sd32767, 16'sd32767);
    send_pos(-16'sd32768, 16'sd32767);
    send_pos(16'sd32767, -16'sd32768);
    send_pos(16'sd0, 16'sd0);
    send_pos(-16'sd1, -16'sd1);
    send_pos(16'sd15, 16'sd16);
    send_pos(16'sd16, 16'sd15);
    send_pos(-16'sd16, -16'sd17);
    send_pos(16'sd1, -16'sd1);
    send_pos(16'sd21845, -16'sd21846);
    send_pos(-16'sd21846, 16'sd21845);
  endtask

  function automatic logic signed [15:0] rand_coord();
    int r, fs;
    r  = $urandom_range(0, 9);
    fs = (cur_size == 0) ? 1 : int'(cur_size);
    if (r < 3) return 16'($urandom);
    if (r < 6) return 16'($urandom_range(0, 128) - 64);
    // near a cell edge: a few cells out, a pixel or two either side
    return 16'(($urandom_range(0, 8) - 4) * fs + $urandom_range(0, 4) - 2);
  endfunction

  function automatic logic [OFS_W-1:0] rand_offset();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r == 3) return {1'b1, {(OFS_W-1){1'b0}}};
    if (r == 4) return {1'b0, {(OFS_W-1){1'b1}}};
    if (r < 7) return OFS_W'($urandom_range(0, 2000) - 1000);
    return OFS_W'($urandom);
  endfunction

  function automatic logic [FS_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return FS_W'(MAX_FIELD_SIZE);
    if (r == 2) return FS_W'(1);
    if (r < 7) return FS_W'($urandom_range(2, 40));
    return FS_W'($urandom);
  endfunction

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    cur_size  = FS_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: square cells, edge 16, no scroll
    directed_set();
    drain();
    // Largest cells in hexagon mode with extreme offsets
    set_regs(FS_W'(MAX_FIELD_SIZE), 1'b1, {1'b1, {(OFS_W-1){1'b0}}},
             {1'b0, {(OFS_W-1){1'b1}}});
    directed_set();
    drain();
    // Zero field size acts as one; saturates far out positions
    set_regs('0, 1'b0, {1'b0, {(OFS_W-1){1'b1}}}, {1'b1, {(OFS_W-1){1'b0}}});
    directed_set();
    drain();
    set_regs(FS_W'(1), 1'b1, '0, '0);
    directed_set();
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      quiet = (ph % 4 == 3);
      set_regs(rand_size(), ph[0], rand_offset(), rand_offset());
      for (int i = 0; i < 80; i++) send_pos(rand_coord(), rand_coord());
      drain();
    end

    if (fails == 0) begin
      $display("pixel_to_hex_or_square_cell test passed");
    end else begin
      $display("pixel_to_hex_or_square_cell test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/pxcell_pkg.sv
rtl/pxcell_div.sv
rtl/pixel_to_hex_or_square_cell.sv
tb/pxcell_checker.sv
tb/tb_top.sv
